FILE: rtl/core/sukt_pkg.sv
`timescale 1ns / 1ps

package sukt_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ECNT_W   = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_ASC,
    CELL_ROT_DESC
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [KEY_W-1:0] key;
    logic               descending;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] key_out;
    logic [ECNT_W-1:0]       entry_count;
    logic                    last;
  } out_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e                op;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sukt_cell.sv
`timescale 1ns / 1ps

module sukt_cell (
  input  logic                              clk_i,
  input  sukt_pkg::cell_ctl_t               ctl_i,
  input  logic                              occ_i,
  input  logic                              is_tail_i,
  input  logic                              left_lt_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] left_key_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] right_key_i,
  input  logic signed [sukt_pkg::KEY_W-1:0] head_key_i,
  output logic signed [sukt_pkg::KEY_W-1:0] key_o,
  output logic                              lt_o,
  output logic                              eq_o
);
  import sukt_pkg::*;

  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] key_d;

  assign lt_o  = occ_i && (key_q < ctl_i.key);
  assign eq_o  = occ_i && (key_q == ctl_i.key);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        // cells below the slot keep, the slot takes the key, the rest move up
        if (!lt_o) begin
          key_d = left_lt_i ? ctl_i.key : left_key_i;
        end
      end
      CELL_DELETE: begin
        if (!lt_o) begin
          key_d = right_key_i;
        end
      end
      CELL_ROT_ASC:  key_d = is_tail_i ? head_key_i : right_key_i;
      CELL_ROT_DESC: key_d = left_key_i;
      default:       key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

FILE: rtl/core/sorted_unique_key_table.sv
`timescale 1ns / 1ps

// Sorted set of up to CAPACITY distinct signed 32-bit keys, built as a row of
// cells that each hold one key and compare it against the command key in
// parallel. Insert, search and delete take the transfer in the idle state, then
// in the execute state every cell compares and shifts toward or away from the
// insert or delete slot at once. A dump passes the execute state, then gives
// one key per cycle from the dump state while the output is not stalled (the
// occupied cells rotate as a ring, which leaves them back in place at the end);
// an empty dump gives one empty result. A stalled output holds the table back.
// No clearing pass after reset: cells above the count are never read.
module sorted_unique_key_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sukt_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sukt_pkg::out_item_t  out_data_o
);
  import sukt_pkg::*;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  in_item_t         cmd_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  // cell row
  cell_ctl_t               cell_ctl;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     cell_occ;
  logic [CAPACITY-1:0]     cell_tail;
  logic signed [KEY_W-1:0] tail_key;

  logic     out_free;
  logic     out_load;
  logic     hit;
  logic     full;
  logic     take_in;
  status_e  status_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign hit      = |cell_eq;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign take_in  = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    assign cell_occ[i]  = (CNT_W'(i) < count_q);
    assign cell_tail[i] = (count_q == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      // slot zero when the first key is not below; ring wrap on descending rotate
      assign left_lt  = 1'b1;
      assign left_key = tail_key;
    end else begin : g_mid
      assign left_lt  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sukt_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .occ_i       (cell_occ[i]),
      .is_tail_i   (cell_tail[i]),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .head_key_i  (cell_key[0]),
      .key_o       (cell_key[i]),
      .lt_o        (cell_lt[i]),
      .eq_o        (cell_eq[i])
    );
  end

  // key of the highest occupied cell, one-hot select
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_tail[i]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take_in) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (cmd_q.cmd == CMD_DUMP && count_q != '0) begin
            state_d = S_DUMP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (out_free && (idx_q == count_q - CNT_W'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall_o   = 1'b1;
    cell_ctl.op  = CELL_HOLD;
    // command key goes to every cell
    cell_ctl.key = cmd_q.key;
    out_load     = 1'b0;
    out_data_d   = out_data_q;
    count_d      = count_q;
    idx_d        = idx_q;
    status_d     = ST_OK;

    case (cmd_q.cmd)
      CMD_INSERT: status_d = hit ? ST_DUP : (full ? ST_FULL : ST_OK);
      CMD_SEARCH: status_d = hit ? ST_OK : ST_MISS;
      CMD_DELETE: status_d = hit ? ST_OK : ST_MISS;
      CMD_DUMP:   status_d = ST_EMPTY;
      default:    status_d = ST_OK;
    endcase

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_EXEC: begin
        if (out_free) begin
          idx_d = '0;
          if (cmd_q.cmd == CMD_DUMP) begin
            // a non-empty dump emits from the dump state
            if (count_q == '0) begin
              out_load               = 1'b1;
              out_data_d.status      = ST_EMPTY;
              out_data_d.key_out     = '0;
              out_data_d.entry_count = '0;
              out_data_d.last        = 1'b1;
            end
          end else begin
            if (cmd_q.cmd == CMD_INSERT && status_d == ST_OK) begin
              cell_ctl.op = CELL_INSERT;
              count_d     = count_q + CNT_W'(1);
            end else if (cmd_q.cmd == CMD_DELETE && hit) begin
              cell_ctl.op = CELL_DELETE;
              count_d     = count_q - CNT_W'(1);
            end
            out_load               = 1'b1;
            out_data_d.status      = status_d;
            out_data_d.key_out     = cmd_q.key;
            out_data_d.entry_count = ECNT_W'(count_d);
            out_data_d.last        = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_data_d.status      = ST_OK;
          out_data_d.key_out     = cmd_q.descending ? tail_key : cell_key[0];
          out_data_d.entry_count = ECNT_W'(count_q);
          out_data_d.last        = (idx_q == count_q - CNT_W'(1));
          cell_ctl.op            = cmd_q.descending ? CELL_ROT_DESC : CELL_ROT_ASC;
          idx_d                  = idx_q + CNT_W'(1);
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      cmd_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // only the execute step changes the count
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_EXEC |=> count_q == $past(count_q))
    else $error("entry count changed outside execute");

  // a successful insert grows the table by one
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_free && cmd_q.cmd == CMD_INSERT && status_d == ST_OK)
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the table");

  // a dump run only walks a non-empty table
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> (count_q != '0 && idx_q < count_q))
    else $error("dump index outside the held keys");
`endif

endmodule
